// ----- rtl/krcl_pkg.sv -----
package krcl_pkg;

  localparam int unsigned TableDepthDefault = 256;
  localparam int unsigned KmerWidth = 64;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned MaxKmer = 32;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_LOAD    = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_PUSH    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    LOAD_OK   = 2'd0,
    LOAD_DUP  = 2'd1,
    LOAD_FULL = 2'd2
  } load_status_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_DONE   = 2'd2
  } back_state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  base_char;
    logic [63:0] entry_key;
    logic [15:0] entry_count;
  } in_req_t;

  typedef struct packed {
    logic [63:0] forward_kmer_out;
    logic [63:0] reverse_kmer_out;
    logic [15:0] coverage;
    logic        kmer_ready;
    logic [1:0]  load_status;
  } out_req_t;

  // Classified request handed from the front part to the back part.
  typedef struct packed {
    mode_t       mode;
    logic [63:0] fwd;
    logic [63:0] rev;
    logic        kmer_ready;
    logic [63:0] entry_key;
    logic [15:0] entry_count;
  } job_t;

  // Two-bit base code; a, n and anything unknown give 0.
  function automatic logic [1:0] base_code(input logic [7:0] ch);
    logic [1:0] code;
    code = 2'd0;
    case (ch)
      8'h63, 8'h43: code = 2'd1;
      8'h67, 8'h47: code = 2'd2;
      8'h74, 8'h54: code = 2'd3;
      default:      code = 2'd0;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/krcl_front.sv -----
module krcl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  krcl_pkg::in_req_t in_data,
  input  logic [5:0]        kmer_length,
  output logic              job_valid,
  input  logic              job_ready,
  output krcl_pkg::job_t    job
);

  logic [63:0] fwd_r, fwd_nxt;
  logic [63:0] rev_r, rev_nxt;
  logic [5:0]  seen_r, seen_nxt;
  logic [5:0]  k_eff;
  logic [5:0]  pos;
  logic [63:0] mask;
  logic [1:0]  code;
  logic        accept;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign accept    = in_valid && job_ready;

  // Effective length clamps 0 to 1 and anything above 32 to 32.
  always_comb begin
    if (kmer_length == 6'd0) k_eff = 6'd1;
    else if (kmer_length > 6'(krcl_pkg::MaxKmer)) k_eff = 6'(krcl_pkg::MaxKmer);
    else k_eff = kmer_length;
  end

  assign pos  = 6'({k_eff[4:0], 1'b0} - 6'd2);
  assign mask = (64'd1 << pos) - 64'd1;
  assign code = krcl_pkg::base_code(in_data.base_char);

  // Roll the k-mers for the arriving request.
  always_comb begin
    fwd_nxt  = fwd_r;
    rev_nxt  = rev_r;
    seen_nxt = seen_r;
    case (krcl_pkg::mode_t'(in_data.mode))
      krcl_pkg::MODE_RESTART: begin
        fwd_nxt  = '0;
        rev_nxt  = '0;
        seen_nxt = '0;
      end
      krcl_pkg::MODE_PUSH: begin
        fwd_nxt = ((fwd_r & mask) << 2) | {62'd0, code};
        rev_nxt = (rev_r >> 2) | ({62'd0, code ^ 2'd3} << pos);
        if (seen_r < 6'(krcl_pkg::MaxKmer)) seen_nxt = seen_r + 6'd1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    job.mode        = krcl_pkg::mode_t'(in_data.mode);
    job.fwd         = fwd_nxt;
    job.rev         = rev_nxt;
    job.kmer_ready  = (seen_nxt >= k_eff);
    job.entry_key   = in_data.entry_key;
    job.entry_count = in_data.entry_count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r  <= '0;
      rev_r  <= '0;
      seen_r <= '0;
    end else if (accept) begin
      fwd_r  <= fwd_nxt;
      rev_r  <= rev_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

// ----- rtl/krcl_queue.sv -----
module krcl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  krcl_pkg::job_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output krcl_pkg::job_t rd_data
);

  krcl_pkg::job_t slot_r [krcl_pkg::QueueDepth];
  logic           wptr_r, rptr_r;
  logic [1:0]     cnt_r;
  logic           push, pop;

  assign wr_ready = (cnt_r != 2'(krcl_pkg::QueueDepth));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = slot_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Two-entry queue between front and back.
  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop) rptr_r <= ~rptr_r;
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, pop});
    end
  end

  property p_no_overflow;
    @(posedge clk) disable iff (!rst_n) cnt_r <= 2'(krcl_pkg::QueueDepth);
  endproperty
  assert property (p_no_overflow) else $error("queue count overflow");

  property p_pop_decrements;
    @(posedge clk) disable iff (!rst_n) (pop && !push) |=> (cnt_r == $past(cnt_r) - 2'd1);
  endproperty
  assert property (p_pop_decrements) else $error("queue pop miscounted");

  property p_push_increments;
    @(posedge clk) disable iff (!rst_n) (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1);
  endproperty
  assert property (p_push_increments) else $error("queue push miscounted");

endmodule

// ----- rtl/krcl_back.sv -----
module krcl_back #(
  parameter int unsigned TableDepth = krcl_pkg::TableDepthDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  krcl_pkg::job_t     job,
  output logic               out_valid,
  input  logic               out_ready,
  output krcl_pkg::out_req_t out_data
);

  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned UW = $clog2(TableDepth + 1);

  logic [63:0] keys_mem   [TableDepth];
  logic [15:0] counts_mem [TableDepth];

  krcl_pkg::back_state_t state_r, state_nxt;
  krcl_pkg::job_t        cur_r, cur_nxt;
  logic [UW-1:0]         used_r, used_nxt;
  logic [UW-1:0]         idx_r, idx_nxt;
  logic [15:0]           fcnt_r, fcnt_nxt, rcnt_r, rcnt_nxt;
  logic                  ffound_r, ffound_nxt, rfound_r, rfound_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [63:0]           rd_key_r;
  logic [15:0]           rd_cnt_r;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic                  out_valid_r, out_valid_nxt;
  krcl_pkg::out_req_t    out_r, out_nxt;
  logic                  hit_f, hit_r, hit_any;
  logic                  done_scan;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign job_ready = (state_r == krcl_pkg::ST_IDLE) && !out_valid_r;

  // Registered table read at the scan index.
  always_ff @(posedge clk) begin
    rd_key_r <= keys_mem[idx_r[AW-1:0]];
    rd_cnt_r <= counts_mem[idx_r[AW-1:0]];
    if (wr_en) begin
      keys_mem[wr_addr]   <= cur_r.entry_key;
      counts_mem[wr_addr] <= cur_r.entry_count;
    end
  end

  // K-mer hits only count for a push; a load looks for its own key alone.
  assign hit_f   = rd_pend_r && (cur_r.mode == krcl_pkg::MODE_PUSH) &&
                   (rd_key_r == cur_r.fwd);
  assign hit_r   = rd_pend_r && (cur_r.mode == krcl_pkg::MODE_PUSH) &&
                   (rd_key_r == cur_r.rev);
  assign hit_any = rd_pend_r && (rd_key_r == cur_r.entry_key);
  assign wr_addr = used_r[AW-1:0];

  // Sequencer: one table entry compared per cycle.
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    used_nxt      = used_r;
    idx_nxt       = idx_r;
    fcnt_nxt      = fcnt_r;
    rcnt_nxt      = rcnt_r;
    ffound_nxt    = ffound_r;
    rfound_nxt    = rfound_r;
    rd_pend_nxt   = 1'b0;
    wr_en         = 1'b0;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    done_scan     = 1'b0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      krcl_pkg::ST_IDLE: begin
        if (job_valid && job_ready) begin
          cur_nxt    = job;
          idx_nxt    = '0;
          ffound_nxt = 1'b0;
          rfound_nxt = 1'b0;
          fcnt_nxt   = '0;
          rcnt_nxt   = '0;
          state_nxt  = krcl_pkg::ST_SEARCH;
        end
      end
      krcl_pkg::ST_SEARCH: begin
        // Compare the entry read last cycle.
        if (hit_f && !ffound_r) begin
          ffound_nxt = 1'b1;
          fcnt_nxt   = rd_cnt_r;
        end
        if (hit_r && !rfound_r) begin
          rfound_nxt = 1'b1;
          rcnt_nxt   = rd_cnt_r;
        end
        if (cur_r.mode == krcl_pkg::MODE_LOAD && hit_any) ffound_nxt = 1'b1;
        if (cur_r.mode == krcl_pkg::MODE_CLEAR || cur_r.mode == krcl_pkg::MODE_RESTART) begin
          done_scan = 1'b1;
        end else if (idx_r >= used_r) begin
          if (!rd_pend_r) done_scan = 1'b1;
        end else begin
          rd_pend_nxt = 1'b1;
          idx_nxt     = UW'(idx_r + 1'b1);
        end
        if (done_scan) state_nxt = krcl_pkg::ST_DONE;
      end
      krcl_pkg::ST_DONE: begin
        out_nxt.forward_kmer_out = cur_r.fwd;
        out_nxt.reverse_kmer_out = cur_r.rev;
        out_nxt.kmer_ready       = cur_r.kmer_ready;
        out_nxt.coverage         = '0;
        out_nxt.load_status      = krcl_pkg::LOAD_OK;
        case (cur_r.mode)
          krcl_pkg::MODE_CLEAR: used_nxt = '0;
          krcl_pkg::MODE_LOAD: begin
            if (ffound_r) out_nxt.load_status = krcl_pkg::LOAD_DUP;
            else if (used_r >= UW'(TableDepth)) out_nxt.load_status = krcl_pkg::LOAD_FULL;
            else begin
              wr_en    = 1'b1;
              used_nxt = UW'(used_r + 1'b1);
            end
          end
          krcl_pkg::MODE_PUSH:
            out_nxt.coverage = (fcnt_r > rcnt_r) ? fcnt_r : rcnt_r;
          default: begin
          end
        endcase
        out_valid_nxt = 1'b1;
        state_nxt     = krcl_pkg::ST_IDLE;
      end
      default: state_nxt = krcl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= krcl_pkg::ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    fcnt_r   <= fcnt_nxt;
    rcnt_r   <= rcnt_nxt;
    ffound_r <= ffound_nxt;
    rfound_r <= rfound_nxt;
    out_r    <= out_nxt;
  end

  property p_used_bounded;
    @(posedge clk) disable iff (!rst_n) used_r <= UW'(TableDepth);
  endproperty
  assert property (p_used_bounded) else $error("table fill count beyond depth");

  property p_write_has_room;
    @(posedge clk) disable iff (!rst_n) wr_en |-> (used_r < UW'(TableDepth));
  endproperty
  assert property (p_write_has_room) else $error("table write when full");

  property p_scan_in_range;
    @(posedge clk) disable iff (!rst_n) (state_r == krcl_pkg::ST_SEARCH) |-> (idx_r <= used_r);
  endproperty
  assert property (p_scan_in_range) else $error("scan index past fill count");

endmodule

// ----- rtl/kmer_roll_and_count_lookup.sv -----
// Rolling k-mer builder with a count table. Each request clears the table, loads one
// key and count, restarts the sequence, or pushes a base; each gives exactly one result.
// The front rolls the forward and reverse-complement k-mers in the cycle a request is
// taken, and a two-entry queue passes it to the back, which scans the table one entry
// per cycle through a single registered read port. A push or load scans all stored
// entries before its result, while clear and restart skip the scan. The back takes no new
// request while its result waits, so a stalled receiver fills the queue and then holds
// off the input.
module kmer_roll_and_count_lookup #(
  parameter int unsigned TableDepth = krcl_pkg::TableDepthDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  krcl_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output krcl_pkg::out_req_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [5:0]         cfg_data
);

  logic [5:0]     kmer_length_r;
  logic           q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
  krcl_pkg::job_t q_wr, q_rd;

  assign cfg_ready = 1'b1;

  // Length register.
  always_ff @(posedge clk) begin
    if (!rst_n) kmer_length_r <= 6'(krcl_pkg::MaxKmer);
    else if (cfg_valid) kmer_length_r <= cfg_data;
  end

  krcl_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .kmer_length(kmer_length_r),
    .job_valid(q_wr_valid), .job_ready(q_wr_ready), .job(q_wr)
  );

  krcl_queue u_queue (
    .clk, .rst_n,
    .wr_valid(q_wr_valid), .wr_ready(q_wr_ready), .wr_data(q_wr),
    .rd_valid(q_rd_valid), .rd_ready(q_rd_ready), .rd_data(q_rd)
  );

  krcl_back #(.TableDepth(TableDepth)) u_back (
    .clk, .rst_n,
    .job_valid(q_rd_valid), .job_ready(q_rd_ready), .job(q_rd),
    .out_valid, .out_ready, .out_data
  );

endmodule

// ----- sim/kmer_lookup_checker.sv -----
// Watches the request, result and length-register channels of the k-mer block,
// keeps its own copy of the rolling k-mers and the count table, and compares
// every result with the oldest predicted one.
module kmer_lookup_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  krcl_pkg::in_req_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  krcl_pkg::out_req_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [5:0]         cfg_data,
  output int                 fail_count,
  output int                 pending_count
);

  localparam int Depth = 256;

  logic [5:0]         len_reg;
  logic [63:0]        fwd_kmer;
  logic [63:0]        rev_kmer;
  int                 seen_bases;
  logic [63:0]        key_store [Depth];
  logic [15:0]        count_store [Depth];
  int                 used_entries;
  krcl_pkg::out_req_t expected_results [$];

  assign pending_count = expected_results.size();

  // Two-bit code of a nucleotide character, case-insensitive.
  function automatic logic [1:0] nucleotide_code(input logic [7:0] ch);
    logic [1:0] code;
    code = 2'd0;
    if (ch == "c" || ch == "C") code = 2'd1;
    else if (ch == "g" || ch == "G") code = 2'd2;
    else if (ch == "t" || ch == "T") code = 2'd3;
    return code;
  endfunction

  // Linear search of the stored keys; returns 1 on a hit.
  function automatic bit lookup_count(input logic [63:0] key, output logic [15:0] cnt);
    cnt = '0;
    for (int i = 0; i < used_entries; i++) begin
      if (key_store[i] == key) begin
        cnt = count_store[i];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Applies one request to the predicted state and returns its result.
  function automatic krcl_pkg::out_req_t roll_and_lookup(input krcl_pkg::in_req_t req);
    krcl_pkg::out_req_t res;
    int                 k;
    int                 pos;
    logic [63:0]        mask;
    logic [1:0]         code;
    logic [15:0]        fcnt;
    logic [15:0]        rcnt;
    logic [15:0]        dummy;
    res = '0;
    k = (len_reg == 0) ? 1 : ((len_reg > 32) ? 32 : int'(len_reg));
    case (krcl_pkg::mode_t'(req.mode))
      krcl_pkg::MODE_CLEAR: used_entries = 0;
      krcl_pkg::MODE_LOAD: begin
        if (lookup_count(req.entry_key, dummy)) begin
          res.load_status = krcl_pkg::LOAD_DUP;
        end else if (used_entries >= Depth) begin
          res.load_status = krcl_pkg::LOAD_FULL;
        end else begin
          key_store[used_entries] = req.entry_key;
          count_store[used_entries] = req.entry_count;
          used_entries++;
          res.load_status = krcl_pkg::LOAD_OK;
        end
      end
      krcl_pkg::MODE_RESTART: begin
        fwd_kmer = '0;
        rev_kmer = '0;
        seen_bases = 0;
      end
      default: begin
        code = nucleotide_code(req.base_char);
        pos = 2 * k - 2;
        mask = (64'd1 << pos) - 64'd1;
        fwd_kmer = ((fwd_kmer & mask) << 2) | 64'(code);
        rev_kmer = (rev_kmer >> 2) | (64'(code ^ 2'd3) << pos);
        if (seen_bases < 32) seen_bases++;
        void'(lookup_count(fwd_kmer, fcnt));
        void'(lookup_count(rev_kmer, rcnt));
        res.coverage = (fcnt > rcnt) ? fcnt : rcnt;
      end
    endcase
    res.forward_kmer_out = fwd_kmer;
    res.reverse_kmer_out = rev_kmer;
    res.kmer_ready = (seen_bases >= k);
    return res;
  endfunction

  // Track the register and predict on every accepted request.
  always @(posedge clk) begin
    if (!rst_n) begin
      len_reg <= 6'd32;
      fwd_kmer = '0;
      rev_kmer = '0;
      seen_bases = 0;
      used_entries = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) len_reg <= cfg_data;
      if (in_valid && in_ready)
        expected_results = {expected_results, roll_and_lookup(in_data)};
    end
  end

  // Compare each accepted result with the oldest expectation.
  initial fail_count = 0;
  always @(posedge clk) begin
    krcl_pkg::out_req_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        fail_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (exp_res.forward_kmer_out != out_data.forward_kmer_out)
          $display("%0t: forward k-mer expected %h actual %h", $time,
                   exp_res.forward_kmer_out, out_data.forward_kmer_out);
        if (exp_res.reverse_kmer_out != out_data.reverse_kmer_out)
          $display("%0t: reverse k-mer expected %h actual %h", $time,
                   exp_res.reverse_kmer_out, out_data.reverse_kmer_out);
        if (exp_res.coverage != out_data.coverage)
          $display("%0t: coverage expected %0d actual %0d", $time,
                   exp_res.coverage, out_data.coverage);
        if (exp_res.kmer_ready != out_data.kmer_ready)
          $display("%0t: ready flag expected %0d actual %0d", $time,
                   exp_res.kmer_ready, out_data.kmer_ready);
        if (exp_res.load_status != out_data.load_status)
          $display("%0t: load status expected %0d actual %0d", $time,
                   exp_res.load_status, out_data.load_status);
        if (exp_res != out_data) fail_count++;
      end
    end
  end
endmodule

// ----- sim/tb_kmer_roll_and_count_lookup.sv -----
module tb_kmer_roll_and_count_lookup;

  localparam int WatchdogLimit = 20000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  krcl_pkg::in_req_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  krcl_pkg::out_req_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [5:0]         cfg_data = 6'd32;
  int                 fail_count;
  int                 pending_count;
  bit                 hold_off = 1'b0;
  bit                 steady = 1'b0;
  int                 idle_cycles = 0;
  logic [63:0]        loaded_keys [$];

  always #4 clk = ~clk;

  kmer_roll_and_count_lookup dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  kmer_lookup_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Receiver: random stalls, none while steady, stalled throughout while held off.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else out_ready <= steady || ($urandom_range(99) >= 22);
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one request and wait for it to be taken, with an optional gap first.
  // Valid stays high afterward so that the next request can follow at once.
  task automatic send_request(input krcl_pkg::mode_t md, input logic [7:0] ch,
                              input logic [63:0] key, input logic [15:0] cnt);
    krcl_pkg::in_req_t req;
    req.mode = md;
    req.base_char = ch;
    req.entry_key = key;
    req.entry_count = cnt;
    while (!steady && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic push_char(input logic [7:0] ch);
    send_request(krcl_pkg::MODE_PUSH, ch, {$urandom, $urandom}, 16'($urandom));
  endtask

  task automatic load_key(input logic [63:0] key, input logic [15:0] cnt);
    send_request(krcl_pkg::MODE_LOAD, 8'($urandom), key, cnt);
    loaded_keys = {loaded_keys, key};
  endtask

  // Stop offering, let the block drain, then write the k-mer length.
  task automatic set_length(input logic [5:0] len);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] random_char();
    logic [7:0] alphabet [10] = '{"a", "c", "g", "t", "A", "C", "G", "T", "n", "N"};
    if ($urandom_range(9) == 0) return 8'($urandom);
    return alphabet[$urandom_range(9)];
  endfunction

  // Packs a random short sequence into a key for length len.
  function automatic logic [63:0] random_kmer(input int len);
    logic [63:0] key;
    key = {$urandom, $urandom};
    if (len < 32) key &= (64'd1 << (2 * len)) - 64'd1;
    return key;
  endfunction

  initial begin
    logic [5:0] lengths [6] = '{6'd1, 6'd3, 6'd0, 6'd63, 6'd5, 6'd32};
    int         len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of every field, every mode, case and unknown characters.
    load_key('0, 16'd0);
    load_key('1, 16'hFFFF);
    load_key('1, 16'd7);
    load_key(64'hAAAA_AAAA_AAAA_AAAA, 16'h8000);
    push_char("a"); push_char("C"); push_char("g"); push_char("T");
    push_char("n"); push_char(8'hFF); push_char(8'h00); push_char("t");
    send_request(krcl_pkg::MODE_RESTART, 8'hFF, '1, '1);
    push_char("t");
    send_request(krcl_pkg::MODE_CLEAR, '0, '0, '0);
    push_char("a");
    // Fill the table to its limit, then overflow it and hit a duplicate.
    steady = 1'b1;
    for (int i = 0; i < 257; i++) load_key(64'(i) + 64'h100, 16'(i));
    load_key(64'h100, 16'd9);
    steady = 1'b0;
    send_request(krcl_pkg::MODE_CLEAR, '0, '0, '0);
    loaded_keys.delete();

    // Long receiver hold-off so that the block fills and stalls its input.
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (6) push_char(random_char());
    join

    // Random phases under several lengths, extremes included.
    foreach (lengths[p]) begin
      set_length(lengths[p]);
      len = (lengths[p] == 0) ? 1 : ((lengths[p] > 32) ? 32 : lengths[p]);
      steady = (p == 3);
      send_request(krcl_pkg::MODE_CLEAR, '0, '0, '0);
      loaded_keys.delete();
      repeat (8) load_key(random_kmer(len), 16'($urandom));
      for (int n = 0; n < 20; n++) begin
        case ($urandom_range(19))
          0: send_request(krcl_pkg::MODE_RESTART, 8'($urandom), {$urandom, $urandom},
                          16'($urandom));
          1: send_request(krcl_pkg::MODE_CLEAR, 8'($urandom), {$urandom, $urandom},
                          16'($urandom));
          2, 3: load_key(random_kmer(len), 16'($urandom));
          4: if (loaded_keys.size() != 0)
               load_key(loaded_keys[$urandom_range(loaded_keys.size() - 1)],
                        16'($urandom));
          default: push_char(random_char());
        endcase
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
